>>> src/rblc_pkg.sv
// Shared constants, codes and types for the row block LRU tag cache.
package rblc_pkg;

    localparam int ENTRIES  = 16;
    localparam int ROW_BITS = 32;

    // The row port is 32 bits wide, so at most 32 dividend bits take part.
    localparam int DIV_BITS = (ROW_BITS < 32) ? ROW_BITS : 32;
    localparam int STEP_W   = $clog2(DIV_BITS);
    localparam int IDX_W    = $clog2(ENTRIES);
    localparam int RANK_W   = IDX_W;
    localparam int CNT_W    = $clog2(ENTRIES + 1);
    localparam int LIM_W    = (CNT_W > 5) ? CNT_W : 5;

    localparam logic [15:0] RESET_BLOCK_SIZE = 16'd1024;
    localparam logic [4:0]  RESET_MAX_BLOCKS = 5'd10;

    localparam logic [1:0] FUNC_ACCESS = 2'd0;
    localparam logic [1:0] FUNC_PROBE  = 2'd1;
    localparam logic [1:0] FUNC_CLEAR  = 2'd2;
    localparam logic [1:0] FUNC_NONE   = 2'd3;

    localparam logic REG_BLOCK_SIZE = 1'b0;
    localparam logic REG_MAX_BLOCKS = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIVIDE,
        ST_SCAN,
        ST_UPDATE,
        ST_DONE
    } state_t;

endpackage

>>> src/row_block_lru_tag_cache.sv
// Row to block mapping with a serial divider and a fully associative LRU tag store.
// Access/probe: accepted at start & !busy; done pulses after the divide, scan and
// update steps: one quotient bit per cycle, then one tag entry compared per cycle.
// A new transaction is accepted only once the previous one is done and busy is low.
// Clear and the unused code go straight to the done step. Results cannot be stalled.
// Reset empties the store and loads block_size 1024, max_blocks 10.
module row_block_lru_tag_cache
    import rblc_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  func,
    input  logic [31:0] row,
    input  logic        wr_en,
    input  logic        wr_index,
    input  logic [15:0] wr_data,
    output logic        done,
    output logic [31:0] block_index,
    output logic [15:0] block_offset,
    output logic        hit,
    output logic [3:0]  slot,
    output logic        evicted,
    output logic [31:0] evicted_block
);

    state_t state_reg, state_next;

    logic [15:0]         block_size_reg;
    logic [4:0]          max_blocks_reg;

    logic [31:0]         tag_store_reg [ENTRIES];
    logic [ENTRIES-1:0]  valid_reg;
    logic [RANK_W-1:0]   rank_reg [ENTRIES];
    logic [CNT_W-1:0]    held_count_reg;

    logic [1:0]          func_reg;
    logic [DIV_BITS-1:0] dvd_reg;
    logic [15:0]         rem_reg;
    logic [STEP_W-1:0]   step_reg;
    logic [IDX_W-1:0]    scan_idx_reg;

    logic                found_reg;
    logic [IDX_W-1:0]    found_idx_reg;
    logic [RANK_W-1:0]   found_rank_reg;
    logic                any_reg;
    logic [IDX_W-1:0]    lru_idx_reg;
    logic [RANK_W-1:0]   worst_reg;
    logic [31:0]         lru_tag_reg;
    logic                free_found_reg;
    logic [IDX_W-1:0]    free_idx_reg;

    logic [31:0]         block_index_reg;
    logic [15:0]         block_offset_reg;
    logic                hit_reg;
    logic [3:0]          slot_reg;
    logic                evicted_reg;
    logic [31:0]         evicted_block_reg;

    logic                accept;
    logic [15:0]         div_val;
    logic [16:0]         trial;
    logic [16:0]         diff;
    logic                ge;
    logic [15:0]         rem_next;
    logic [31:0]         tag_now;
    logic [31:0]         scan_tag;
    logic                scan_valid;
    logic [RANK_W-1:0]   scan_rank;
    logic [LIM_W-1:0]    limit;
    logic                at_limit;
    logic                do_evict;
    logic [IDX_W-1:0]    target;

    assign accept  = start && !busy;
    assign div_val = (block_size_reg == 16'd0) ? 16'd1 : block_size_reg;

    // restoring divider, one quotient bit per cycle shifted into dvd_reg
    assign trial    = {rem_reg, dvd_reg[DIV_BITS-1]};
    assign diff     = trial - {1'b0, div_val};
    assign ge       = (trial >= {1'b0, div_val});
    assign rem_next = ge ? diff[15:0] : trial[15:0];
    assign tag_now  = 32'(dvd_reg);

    assign scan_tag   = tag_store_reg[scan_idx_reg];
    assign scan_valid = valid_reg[scan_idx_reg];
    assign scan_rank  = rank_reg[scan_idx_reg];

    always_comb
    begin
        if (max_blocks_reg == 5'd0)
            limit = LIM_W'(1);
        else if (LIM_W'(max_blocks_reg) > LIM_W'(ENTRIES))
            limit = LIM_W'(ENTRIES);
        else
            limit = LIM_W'(max_blocks_reg);
    end

    assign at_limit = (LIM_W'(held_count_reg) >= limit);
    assign do_evict = at_limit && any_reg;
    assign target   = do_evict ? lru_idx_reg : free_idx_reg;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (func == FUNC_ACCESS || func == FUNC_PROBE)
                        state_next = ST_DIVIDE;
                    else
                        state_next = ST_DONE;
                end
            end
            ST_DIVIDE:
            begin
                if (step_reg == '0)
                    state_next = ST_SCAN;
            end
            ST_SCAN:
            begin
                if (scan_idx_reg == IDX_W'(ENTRIES - 1))
                    state_next = ST_UPDATE;
            end
            ST_UPDATE: state_next = ST_DONE;
            ST_DONE:   state_next = ST_IDLE;
            default:   state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        busy = 1'b1;
        done = 1'b0;
        case (state_reg)
            ST_IDLE: busy = 1'b0;
            ST_DONE: done = 1'b1;
            default: busy = 1'b1;
        endcase
    end

    assign block_index   = block_index_reg;
    assign block_offset  = block_offset_reg;
    assign hit           = hit_reg;
    assign slot          = slot_reg;
    assign evicted       = evicted_reg;
    assign evicted_block = evicted_block_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            block_size_reg <= RESET_BLOCK_SIZE;
            max_blocks_reg <= RESET_MAX_BLOCKS;
            valid_reg      <= '0;
            held_count_reg <= '0;
            for (int i = 0; i < ENTRIES; i++)
            begin
                rank_reg[i] <= '0;
            end
        end
        else
        begin
            state_reg <= state_next;

            if (wr_en)
            begin
                if (wr_index == REG_BLOCK_SIZE)
                    block_size_reg <= wr_data;
                else
                    max_blocks_reg <= wr_data[4:0];
            end

            if (state_reg == ST_IDLE && accept && func == FUNC_CLEAR)
            begin
                valid_reg      <= '0;
                held_count_reg <= '0;
                for (int i = 0; i < ENTRIES; i++)
                begin
                    rank_reg[i] <= '0;
                end
            end

            if (state_reg == ST_UPDATE)
            begin
                if (found_reg)
                begin
                    for (int i = 0; i < ENTRIES; i++)
                    begin
                        if (IDX_W'(i) == found_idx_reg)
                            rank_reg[i] <= '0;
                        else if (valid_reg[i] && rank_reg[i] < found_rank_reg)
                            rank_reg[i] <= rank_reg[i] + 1'b1;
                    end
                end
                else if (func_reg == FUNC_ACCESS)
                begin
                    for (int i = 0; i < ENTRIES; i++)
                    begin
                        if (IDX_W'(i) == target)
                        begin
                            rank_reg[i]  <= '0;
                            valid_reg[i] <= 1'b1;
                        end
                        else if (valid_reg[i])
                        begin
                            rank_reg[i] <= rank_reg[i] + 1'b1;
                        end
                    end
                    if (!do_evict)
                        held_count_reg <= held_count_reg + 1'b1;
                end
            end
        end
    end

    // datapath registers, no reset needed
    always_ff @(posedge clk)
    begin
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    func_reg          <= func;
                    dvd_reg           <= row[DIV_BITS-1:0];
                    rem_reg           <= '0;
                    step_reg          <= STEP_W'(DIV_BITS - 1);
                    scan_idx_reg      <= '0;
                    found_reg         <= 1'b0;
                    found_idx_reg     <= '0;
                    found_rank_reg    <= '0;
                    any_reg           <= 1'b0;
                    lru_idx_reg       <= '0;
                    worst_reg         <= '0;
                    lru_tag_reg       <= '0;
                    free_found_reg    <= 1'b0;
                    free_idx_reg      <= '0;
                    block_index_reg   <= '0;
                    block_offset_reg  <= '0;
                    hit_reg           <= 1'b0;
                    slot_reg          <= '0;
                    evicted_reg       <= 1'b0;
                    evicted_block_reg <= '0;
                end
            end
            ST_DIVIDE:
            begin
                rem_reg  <= rem_next;
                dvd_reg  <= {dvd_reg[DIV_BITS-2:0], ge};
                step_reg <= step_reg - 1'b1;
            end
            ST_SCAN:
            begin
                // first matching entry, the oldest valid entry, and the first free entry
                if (scan_valid && scan_tag == tag_now && !found_reg)
                begin
                    found_reg      <= 1'b1;
                    found_idx_reg  <= scan_idx_reg;
                    found_rank_reg <= scan_rank;
                end
                if (scan_valid && (!any_reg || scan_rank > worst_reg))
                begin
                    any_reg     <= 1'b1;
                    worst_reg   <= scan_rank;
                    lru_idx_reg <= scan_idx_reg;
                    lru_tag_reg <= scan_tag;
                end
                if (!scan_valid && !free_found_reg)
                begin
                    free_found_reg <= 1'b1;
                    free_idx_reg   <= scan_idx_reg;
                end
                scan_idx_reg <= scan_idx_reg + 1'b1;
            end
            ST_UPDATE:
            begin
                block_index_reg  <= tag_now;
                block_offset_reg <= rem_reg;
                hit_reg          <= found_reg;
                if (found_reg)
                begin
                    if (func_reg == FUNC_ACCESS)
                        slot_reg <= 4'(found_idx_reg);
                end
                else if (func_reg == FUNC_ACCESS)
                begin
                    tag_store_reg[target] <= tag_now;
                    slot_reg              <= 4'(target);
                    evicted_reg           <= do_evict;
                    evicted_block_reg     <= do_evict ? lru_tag_reg : 32'd0;
                end
            end
            default:
            begin
            end
        endcase
    end

endmodule
